>>> design/bpc_pkg.sv
package bpc_pkg;

    localparam int DATA_W = 32;
    localparam int DIV_STEPS = 32;
    localparam int RAW_T_W = 16;
    localparam int RAW_P_W = 19;
    localparam int TEMP_W = 16;
    localparam int PRES_W = 18;
    localparam int OSS_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OSS = 3'd5;

    localparam logic [DATA_W-1:0] B6_OFFSET = 32'd4000;
    localparam logic [DATA_W-1:0] B4_OFFSET = 32'd32768;
    localparam logic [DATA_W-1:0] B7_SCALE = 32'd50000;
    localparam logic [DATA_W-1:0] P_C1 = 32'd3038;
    localparam logic [DATA_W-1:0] P_C2 = 32'hFFFF_E343;
    localparam logic [DATA_W-1:0] P_C3 = 32'd3791;
    localparam logic [DATA_W-1:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [DATA_W-1:0] PRES_MAX = 32'd262143;

    typedef logic [DATA_W-1:0] t_word;

    function automatic t_word sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_word asr(input t_word v, input int s);
        return t_word'($signed(v) >>> s);
    endfunction

endpackage

>>> design/bpc_div.sv
module bpc_div #(
    parameter int SIDE_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [bpc_pkg::DATA_W-1:0]   i_num,
    input  logic [bpc_pkg::DATA_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_valid,
    output logic [bpc_pkg::DATA_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int W = bpc_pkg::DATA_W;
    localparam int N = bpc_pkg::DIV_STEPS;

    logic          r_v    [N];
    logic [W-1:0]  r_rem  [N];
    logic [W-1:0]  r_num  [N];
    logic [W-1:0]  r_quo  [N];
    logic [W-1:0]  r_den  [N];
    logic [SIDE_W-1:0] r_side [N];

    // One quotient bit is resolved per stage, restoring style.
    for (genvar k = 0; k < N; k++) begin : g_step
        logic          w_v;
        logic [W-1:0]  w_rem;
        logic [W-1:0]  w_num;
        logic [W-1:0]  w_quo;
        logic [W-1:0]  w_den;
        logic [SIDE_W-1:0] w_side;
        logic [W:0]    w_sh;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_v = i_valid;
            assign w_rem = '0;
            assign w_num = i_num;
            assign w_quo = '0;
            assign w_den = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v = r_v[k-1];
            assign w_rem = r_rem[k-1];
            assign w_num = r_num[k-1];
            assign w_quo = r_quo[k-1];
            assign w_den = r_den[k-1];
            assign w_side = r_side[k-1];
        end

        assign w_sh = {w_rem, w_num[W-1]};
        assign w_ge = (w_sh >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? W'(w_sh - {1'b0, w_den}) : w_sh[W-1:0];
                r_num[k] <= {w_num[W-2:0], 1'b0};
                r_quo[k] <= {w_quo[W-2:0], w_ge};
                r_den[k] <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo = r_quo[N-1];
    assign o_side = r_side[N-1];

endmodule

>>> design/barometric_pressure_compensation_unit.sv
// Barometric pressure compensation unit.
// Input channel: i_valid / o_stall with i_raw_temperature and i_raw_pressure;
// a sample is taken at a clock edge where i_valid is high and o_stall low.
// Output channel: o_valid / i_stall with o_temperature_tenths (0.1 degC),
// o_pressure_pa and o_divide_error; a result leaves when o_valid is high
// and i_stall low. A zero divisor gives zero results with the error flag.
// Coefficients are written through i_cfg_valid / o_cfg_ready, index and
// data; o_cfg_ready is always high. Write them only while the unit is idle.
// Results pass through the two 32-stage restoring dividers plus the multiply
// stages around them. One sample is taken per cycle while the output is not
// stalled. When the receiver stalls a valid result, the whole pipeline holds
// and o_stall rises; nothing is lost or repeated. Bubbles in the pipeline
// do not hold it back. Reset clears every valid bit and every coefficient
// register to zero.
module barometric_pressure_compensation_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bpc_pkg::RAW_T_W-1:0]          i_raw_temperature,
    input  logic [bpc_pkg::RAW_P_W-1:0]          i_raw_pressure,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [bpc_pkg::TEMP_W-1:0]    o_temperature_tenths,
    output logic [bpc_pkg::PRES_W-1:0]           o_pressure_pa,
    output logic                                 o_divide_error,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bpc_pkg::DATA_W-1:0]           i_cfg_data
);

    localparam int W = bpc_pkg::DATA_W;
    localparam int PW = bpc_pkg::RAW_P_W;
    localparam int TW = bpc_pkg::TEMP_W;
    localparam int SA_W = W + PW + 2;
    localparam int SB_W = TW + 2;

    logic [W-1:0] r_c0, r_c1, r_c2, r_c3, r_c4;
    logic [bpc_pkg::OSS_W-1:0] r_oss;

    logic en;
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_oss <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpc_pkg::REG_AC1_AC2: r_c0 <= i_cfg_data;
                bpc_pkg::REG_AC3_AC4: r_c1 <= i_cfg_data;
                bpc_pkg::REG_AC5_AC6: r_c2 <= i_cfg_data;
                bpc_pkg::REG_B1_B2:   r_c3 <= i_cfg_data;
                bpc_pkg::REG_MC_MD:   r_c4 <= i_cfg_data;
                bpc_pkg::REG_OSS:     r_oss <= i_cfg_data[bpc_pkg::OSS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = bpc_pkg::sext16(r_c0[31:16]);
    assign ac2 = bpc_pkg::sext16(r_c0[15:0]);
    assign ac3 = bpc_pkg::sext16(r_c1[31:16]);
    assign ac4 = {16'd0, r_c1[15:0]};
    assign ac5 = {16'd0, r_c2[31:16]};
    assign ac6 = {16'd0, r_c2[15:0]};
    assign b1 = bpc_pkg::sext16(r_c3[31:16]);
    assign b2 = bpc_pkg::sext16(r_c3[15:0]);
    assign mc = bpc_pkg::sext16(r_c4[31:16]);
    assign md = bpc_pkg::sext16(r_c4[15:0]);

    // Front stages: temperature product, X1 and the divisor, magnitudes.
    logic r_v1, r_v2, r_v3;
    logic [W-1:0] r_s1_prod;
    logic [PW-1:0] r_s1_up, r_s2_up, r_s3_up;
    logic [W-1:0] r_s2_x1, r_s2_den, r_s3_x1, r_s3_num, r_s3_den;
    logic r_s3_err, r_s3_neg;
    logic [W-1:0] mc_sh;
    assign mc_sh = mc << 11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_prod <= W'(({16'd0, i_raw_temperature} - ac6) * ac5);
            r_s1_up <= i_raw_pressure;
            r_s2_x1 <= bpc_pkg::asr(r_s1_prod, 15);
            r_s2_den <= bpc_pkg::asr(r_s1_prod, 15) + md;
            r_s2_up <= r_s1_up;
            r_s3_x1 <= r_s2_x1;
            r_s3_up <= r_s2_up;
            r_s3_err <= (r_s2_den == '0);
            r_s3_neg <= mc_sh[W-1] ^ r_s2_den[W-1];
            r_s3_num <= mc_sh[W-1] ? W'(-mc_sh) : mc_sh;
            r_s3_den <= r_s2_den[W-1] ? W'(-r_s2_den) : r_s2_den;
        end
    end

    logic da_v;
    logic [W-1:0] da_q;
    logic [SA_W-1:0] da_side;

    bpc_div #(.SIDE_W(SA_W)) u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v3),
        .i_num(r_s3_num), .i_den(r_s3_den),
        .i_side({r_s3_x1, r_s3_up, r_s3_err, r_s3_neg}),
        .o_valid(da_v), .o_quo(da_q), .o_side(da_side)
    );

    logic [W-1:0] da_x1;
    logic [PW-1:0] da_up;
    logic da_err, da_neg;
    assign {da_x1, da_up, da_err, da_neg} = da_side;

    // Middle stages: B5, the temperature, B6, B3, B4 and B7.
    logic [7:0] r_vm;
    logic [W-1:0] r_s4_b5, r_s5_b6, r_s6_sq, r_s6_a2b6, r_s6_a3b6;
    logic [W-1:0] r_s7_b2sq, r_s7_b1sq, r_s7_x2, r_s7_x1b;
    logic [W-1:0] r_s8_b3, r_s8_x3, r_s9_b4, r_s9_upb3, r_s10_b4, r_s10_b7;
    logic [W-1:0] r_s11_num, r_s11_den;
    logic [TW-1:0] r_s5_t, r_s6_t, r_s7_t, r_s8_t, r_s9_t, r_s10_t, r_s11_t;
    logic [PW-1:0] r_s4_up, r_s5_up, r_s6_up, r_s7_up, r_s8_up;
    logic r_s4_err, r_s5_err, r_s6_err, r_s7_err, r_s8_err, r_s9_err, r_s10_err;
    logic r_s11_err, r_s11_hi;

    logic [W-1:0] x2_t, b5_r, tt, b3_x3, b3_sum, b4_x3, b4_prod, up_w;
    assign x2_t = da_neg ? W'(-da_q) : da_q;
    assign tt = bpc_pkg::asr(r_s4_b5 + 32'd8, 4);
    assign b3_x3 = bpc_pkg::asr(r_s7_b2sq, 11) + r_s7_x2;
    assign b3_sum = ((W'(ac1 << 2) + b3_x3) << r_oss) + 32'd2;
    assign b4_x3 = bpc_pkg::asr(r_s7_x1b + bpc_pkg::asr(r_s7_b1sq, 16) + 32'd2, 2);
    assign b4_prod = W'(ac4 * (r_s8_x3 + bpc_pkg::B4_OFFSET));
    assign up_w = {{(W-PW){1'b0}}, r_s8_up};
    assign b5_r = da_x1 + x2_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= '0;
        end else if (en) begin
            r_vm <= {r_vm[6:0], da_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_b5 <= b5_r;
            r_s4_up <= da_up;
            r_s4_err <= da_err;

            r_s5_b6 <= r_s4_b5 - bpc_pkg::B6_OFFSET;
            if ($signed(tt) > $signed(32'sd32767)) begin
                r_s5_t <= 16'h7FFF;
            end else if ($signed(tt) < $signed(-32'sd32768)) begin
                r_s5_t <= 16'h8000;
            end else begin
                r_s5_t <= tt[TW-1:0];
            end
            r_s5_up <= r_s4_up;
            r_s5_err <= r_s4_err;

            r_s6_sq <= W'(r_s5_b6 * r_s5_b6);
            r_s6_a2b6 <= W'(ac2 * r_s5_b6);
            r_s6_a3b6 <= W'(ac3 * r_s5_b6);
            r_s6_t <= r_s5_t;
            r_s6_up <= r_s5_up;
            r_s6_err <= r_s5_err;

            r_s7_b2sq <= W'(b2 * bpc_pkg::asr(r_s6_sq, 12));
            r_s7_b1sq <= W'(b1 * bpc_pkg::asr(r_s6_sq, 12));
            r_s7_x2 <= bpc_pkg::asr(r_s6_a2b6, 11);
            r_s7_x1b <= bpc_pkg::asr(r_s6_a3b6, 13);
            r_s7_t <= r_s6_t;
            r_s7_up <= r_s6_up;
            r_s7_err <= r_s6_err;

            r_s8_b3 <= bpc_pkg::asr(b3_sum, 2);
            r_s8_x3 <= b4_x3;
            r_s8_t <= r_s7_t;
            r_s8_up <= r_s7_up;
            r_s8_err <= r_s7_err;

            r_s9_b4 <= b4_prod >> 15;
            r_s9_upb3 <= up_w - r_s8_b3;
            r_s9_t <= r_s8_t;
            r_s9_err <= r_s8_err;

            r_s10_b7 <= W'(r_s9_upb3 * (bpc_pkg::B7_SCALE >> r_oss));
            r_s10_b4 <= r_s9_b4;
            r_s10_t <= r_s9_t;
            r_s10_err <= r_s9_err || (r_s9_b4 == '0);

            // A large B7 is divided first and doubled after, to stay in 32 bits.
            r_s11_hi <= r_s10_b7[W-1];
            r_s11_num <= r_s10_b7[W-1] ? r_s10_b7 : (r_s10_b7 << 1);
            r_s11_den <= r_s10_b4;
            r_s11_t <= r_s10_t;
            r_s11_err <= r_s10_err;
        end
    end

    logic db_v;
    logic [W-1:0] db_q;
    logic [SB_W-1:0] db_side;

    bpc_div #(.SIDE_W(SB_W)) u_div_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_vm[7]),
        .i_num(r_s11_num), .i_den(r_s11_den),
        .i_side({r_s11_t, r_s11_err, r_s11_hi}),
        .o_valid(db_v), .o_quo(db_q), .o_side(db_side)
    );

    logic [TW-1:0] db_t;
    logic db_err, db_hi;
    assign {db_t, db_err, db_hi} = db_side;

    // Back stages: polynomial correction and saturation.
    logic r_v12, r_v13, r_out_v;
    logic [W-1:0] r_s12_p, r_s12_sq, r_s12_m2, r_s13_p, r_s13_xa, r_s13_xb;
    logic [TW-1:0] r_s12_t, r_s13_t, r_out_t;
    logic r_s12_err, r_s13_err, r_out_err;
    logic [bpc_pkg::PRES_W-1:0] r_out_p;
    logic [W-1:0] p_q, p_x1, p_fin;

    assign p_q = db_hi ? (db_q << 1) : db_q;
    assign p_x1 = bpc_pkg::asr(p_q, 8);
    assign p_fin = r_s13_p
                 + bpc_pkg::asr(r_s13_xa + r_s13_xb + bpc_pkg::P_C3, 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v12 <= 1'b0;
            r_v13 <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v12 <= db_v;
            r_v13 <= r_v12;
            r_out_v <= r_v13;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s12_p <= p_q;
            r_s12_sq <= W'(p_x1 * p_x1);
            r_s12_m2 <= W'(bpc_pkg::P_C2 * p_q);
            r_s12_t <= db_t;
            r_s12_err <= db_err;

            r_s13_p <= r_s12_p;
            r_s13_xa <= bpc_pkg::asr(W'(r_s12_sq * bpc_pkg::P_C1), 16);
            r_s13_xb <= bpc_pkg::asr(r_s12_m2, 16);
            r_s13_t <= r_s12_t;
            r_s13_err <= r_s12_err;

            r_out_err <= r_s13_err;
            if (r_s13_err) begin
                r_out_t <= '0;
                r_out_p <= '0;
            end else begin
                r_out_t <= r_s13_t;
                if ((p_fin & bpc_pkg::SIGN_BIT) != '0) begin
                    r_out_p <= '0;
                end else if (p_fin > bpc_pkg::PRES_MAX) begin
                    r_out_p <= bpc_pkg::PRES_MAX[bpc_pkg::PRES_W-1:0];
                end else begin
                    r_out_p <= p_fin[bpc_pkg::PRES_W-1:0];
                end
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_temperature_tenths = r_out_t;
    assign o_pressure_pa = r_out_p;
    assign o_divide_error = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |-> (o_pressure_pa == '0 && o_temperature_tenths == '0))
        else $error("divide error result not zeroed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result valid straight after reset");

endmodule
